>>> hdl/wcm_pkg.sv
// wcm_pkg: shared widths, codes and state encoding of the word concatenation matcher
// no dependencies; used by the channel interfaces, the top level and the checker

package wcm_pkg;

    // fixed field widths
    localparam int ACTION_W     = 2;
    localparam int LETTER_W     = 5;
    localparam int WORD_INDEX_W = 3;
    localparam int WORD_VALUE_W = 40;
    localparam int POS_W        = 32;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    // text position saturates here
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // input beat actions; code 3 does nothing
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_LETTER  = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_LENGTH = 1'b0,
        REG_WORD_COUNT  = 1'b1
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FILL,
        S_CMP,
        S_DONE
    } state_t;

endpackage

>>> hdl/wcm_if.sv
// wcm_if: valid/ready channel interfaces for input beats and result beats
// depends on wcm_pkg for the field widths

interface wcm_in_if;
    logic                              valid;
    logic                              ready;
    logic [wcm_pkg::ACTION_W-1:0]      action;
    logic [wcm_pkg::LETTER_W-1:0]      letter;
    logic [wcm_pkg::WORD_INDEX_W-1:0]  word_index;
    logic [wcm_pkg::WORD_VALUE_W-1:0]  word_value;

    modport source (output valid, action, letter, word_index, word_value, input ready);
    modport sink   (input valid, action, letter, word_index, word_value, output ready);
endinterface

interface wcm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        match;
    logic [wcm_pkg::POS_W-1:0]   start_index;

    modport source (output valid, match, start_index, input ready);
    modport sink   (input valid, match, start_index, output ready);
endinterface

>>> hdl/word_concatenation_matcher.sv
// word_concatenation_matcher: finds windows of the text that are a permutation of a word set
// depends on wcm_pkg and the channel interfaces in wcm_if.sv
//
// channel    dir  handshake        payload
// in_ch      in   valid/ready      action, letter, word_index, word_value
// out_ch     out  valid/ready      match, start_index
// cfg        in   cfg_write only   cfg_index, cfg_data (word_length, word_count)
//
// load, restart and idle codes, and letters before a full window go from idle straight to done
// letter with a full window: per chunk, wl letters are read one per cycle from the history
// memory port, then a fill state, then one table slot per compare cycle
// in_ch.ready is high only while the sequencer idles; a waiting result beat holds in the
// output register and stalls only the hand-over of the next result
// reset clears the control state; history and word table hold garbage until written

module word_concatenation_matcher #(
    parameter int MAX_WORDS    = 8,
    parameter int MAX_WORD_LEN = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wcm_pkg::CFG_W-1:0]       cfg_data,
    wcm_in_if.sink                          in_ch,
    wcm_out_if.source                       out_ch
);

    localparam int HIST_DEPTH = MAX_WORDS * MAX_WORD_LEN;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HIST_SIZE  = 1 << HIST_AW;
    localparam int SLOT_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LW         = wcm_pkg::LETTER_W;
    localparam int CHUNK_W    = MAX_WORD_LEN * LW;
    localparam int CNT_W      = wcm_pkg::CFG_W;
    localparam int POS_W      = wcm_pkg::POS_W;

    // storage
    logic [LW-1:0]                    hist_mem [HIST_SIZE];
    logic [wcm_pkg::WORD_VALUE_W-1:0] word_table_reg [MAX_WORDS];
    logic [LW-1:0]                    rd_data_reg;

    // control registers
    wcm_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     wl_reg, wl_next;
    logic [CNT_W-1:0]     wc_reg, wc_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [HIST_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [HIST_AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]     c_reg, c_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     s_reg, s_next;
    logic [CNT_W-1:0]     put_k_reg, put_k_next;
    logic                 put_valid_reg, put_valid_next;
    logic [MAX_WORDS-1:0] used_reg, used_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic                 res_match_reg, res_match_next;
    logic [POS_W-1:0]     res_start_reg, res_start_next;
    logic                 out_match_reg, out_match_next;
    logic [POS_W-1:0]     out_start_reg, out_start_next;

    // combinational helpers
    logic                 in_ready;
    logic                 in_fire;
    logic                 hist_we;
    logic                 tbl_we;
    logic [CNT_W-1:0]     wl_eff, wc_eff;
    logic [2*CNT_W-1:0]   total;
    logic [POS_W:0]       pos_inc;
    logic                 window_ok;
    logic [POS_W-1:0]     win_start;
    logic [HIST_AW-1:0]   win_addr;
    logic [CHUNK_W-1:0]   len_mask;
    logic [CHUNK_W-1:0]   tbl_word;
    logic                 slot_hit;

    assign in_ready     = (state_reg == wcm_pkg::S_IDLE);
    assign in_fire      = in_ch.valid && in_ready;
    assign in_ch.ready  = in_ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.match       = out_match_reg;
    assign out_ch.start_index = out_start_reg;

    // register values clamped into range
    always_comb
    begin
        if (wl_reg == '0)
            wl_eff = CNT_W'(1);
        else if (32'(wl_reg) > MAX_WORD_LEN)
            wl_eff = CNT_W'(MAX_WORD_LEN);
        else
            wl_eff = wl_reg;

        if (wc_reg == '0)
            wc_eff = CNT_W'(1);
        else if (32'(wc_reg) > MAX_WORDS)
            wc_eff = CNT_W'(MAX_WORDS);
        else
            wc_eff = wc_reg;
    end

    // window size, start position and start address in the history ring
    assign total     = wl_eff * wc_eff;
    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign window_ok = pos_inc >= (POS_W+1)'(total);
    assign win_start = POS_W'(pos_inc - (POS_W+1)'(total));
    assign win_addr  = wr_ptr_reg + HIST_AW'(1) - HIST_AW'(total);

    // letters beyond word_length take no part in a compare
    always_comb
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            len_mask[i*LW +: LW] = (i < 32'(wl_eff)) ? {LW{1'b1}} : {LW{1'b0}};
        end
    end

    // shared compare unit: one table slot against the current chunk
    assign tbl_word = CHUNK_W'(word_table_reg[s_reg[SLOT_W-1:0]]);
    assign slot_hit = !used_reg[s_reg[SLOT_W-1:0]] &&
                      (((tbl_word ^ chunk_reg) & len_mask) == '0);

    // sequencer next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        wl_next        = wl_reg;
        wc_next        = wc_reg;
        pos_next       = pos_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_addr_next   = rd_addr_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        put_k_next     = k_reg;
        put_valid_next = 1'b0;
        used_next      = used_reg;
        chunk_next     = chunk_reg;
        res_match_next = res_match_reg;
        res_start_next = res_start_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_match_next = out_match_reg;
        out_start_next = out_start_reg;
        hist_we        = 1'b0;
        tbl_we         = 1'b0;

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                wcm_pkg::REG_WORD_LENGTH: wl_next = cfg_data;
                wcm_pkg::REG_WORD_COUNT:  wc_next = cfg_data;
                default:                  wl_next = wl_reg;
            endcase
        end

        // letter read in the previous cycle lands in the chunk
        if (put_valid_reg)
            chunk_next[LW*put_k_reg +: LW] = rd_data_reg;

        case (state_reg)
            wcm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    res_match_next = 1'b0;
                    res_start_next = '0;
                    state_next     = wcm_pkg::S_DONE;
                    case (in_ch.action)
                        wcm_pkg::ACT_LOAD:
                        begin
                            tbl_we = 32'(in_ch.word_index) < MAX_WORDS;
                        end
                        wcm_pkg::ACT_LETTER:
                        begin
                            hist_we     = 1'b1;
                            wr_ptr_next = wr_ptr_reg + HIST_AW'(1);
                            if (pos_reg != wcm_pkg::POS_MAX)
                                pos_next = pos_inc[POS_W-1:0];
                            if (window_ok)
                            begin
                                res_start_next = win_start;
                                rd_addr_next   = win_addr;
                                c_next         = '0;
                                k_next         = '0;
                                s_next         = '0;
                                used_next      = '0;
                                state_next     = wcm_pkg::S_READ;
                            end
                        end
                        wcm_pkg::ACT_RESTART:
                        begin
                            pos_next = '0;
                        end
                        default:
                        begin
                            pos_next = pos_reg;
                        end
                    endcase
                end
            end

            // issue one history read per cycle, oldest letter of the chunk first
            wcm_pkg::S_READ:
            begin
                put_valid_next = 1'b1;
                put_k_next     = k_reg;
                rd_addr_next   = rd_addr_reg + HIST_AW'(1);
                k_next         = k_reg + CNT_W'(1);
                if (k_reg == wl_eff - CNT_W'(1))
                    state_next = wcm_pkg::S_FILL;
            end

            // last letter of the chunk lands
            wcm_pkg::S_FILL:
            begin
                s_next     = '0;
                state_next = wcm_pkg::S_CMP;
            end

            // walk the table slots until an unused slot matches or the last slot misses
            wcm_pkg::S_CMP:
            begin
                if (slot_hit)
                begin
                    used_next[s_reg[SLOT_W-1:0]] = 1'b1;
                    if (c_reg == wc_eff - CNT_W'(1))
                    begin
                        res_match_next = 1'b1;
                        state_next     = wcm_pkg::S_DONE;
                    end
                    else
                    begin
                        c_next     = c_reg + CNT_W'(1);
                        k_next     = '0;
                        state_next = wcm_pkg::S_READ;
                    end
                end
                else if (s_reg == wc_eff - CNT_W'(1))
                begin
                    res_match_next = 1'b0;
                    res_start_next = '0;
                    state_next     = wcm_pkg::S_DONE;
                end
                else
                begin
                    s_next = s_reg + CNT_W'(1);
                end
            end

            // hand the result to the output register once it is free
            wcm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = res_match_reg;
                    out_start_next = res_start_reg;
                    state_next     = wcm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wcm_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wcm_pkg::S_IDLE;
            wl_reg        <= CNT_W'(1);
            wc_reg        <= CNT_W'(1);
            pos_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_addr_reg   <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            s_reg         <= '0;
            put_k_reg     <= '0;
            put_valid_reg <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            wc_reg        <= wc_next;
            pos_reg       <= pos_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_addr_reg   <= rd_addr_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            put_k_reg     <= put_k_next;
            put_valid_reg <= put_valid_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chunk_reg     <= chunk_next;
        res_match_reg <= res_match_next;
        res_start_reg <= res_start_next;
        out_match_reg <= out_match_next;
        out_start_reg <= out_start_next;
    end

    // letter history ring, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wr_ptr_reg] <= in_ch.letter;
        rd_data_reg <= hist_mem[rd_addr_reg];
    end

    // word table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            word_table_reg[SLOT_W'(in_ch.word_index)] <= in_ch.word_value;
    end

endmodule

>>> hdl/wcm_checker.sv
// wcm_checker: port-level assertions for the word concatenation matcher
// depends on wcm_pkg; bound to word_concatenation_matcher at the end of this file

module wcm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      out_match,
    input logic [wcm_pkg::POS_W-1:0] out_start
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_match) && $stable(out_start))
        else $error("result beat changed while stalled");

    // a miss always reports position zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_match |-> out_start == '0)
        else $error("miss with nonzero start index");

    // one beat at a time: the sequencer is busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // a result never appears the cycle right after an accept
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result beat too early");

endmodule

bind word_concatenation_matcher wcm_checker u_wcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_match (out_ch.match),
    .out_start (out_ch.start_index)
);

>>> test/tb_word_concatenation_matcher.sv
// tb_word_concatenation_matcher: self-checking bench for the word concatenation matcher
// predicts the match flag and start position of every input beat and compares result beats
// depends on wcm_pkg, wcm_if.sv and word_concatenation_matcher

module tb_word_concatenation_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WORDS    = 8;
    localparam int MAX_WORD_LEN = 8;
    localparam int HIST_DEPTH   = MAX_WORDS * MAX_WORD_LEN;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 11;
    localparam logic [wcm_pkg::ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef logic [wcm_pkg::LETTER_W-1:0]     letter_t;
    typedef logic [wcm_pkg::WORD_INDEX_W-1:0] slot_t;
    typedef logic [wcm_pkg::WORD_VALUE_W-1:0] word_t;

    typedef struct packed {
        logic [wcm_pkg::ACTION_W-1:0]     action;
        logic [wcm_pkg::LETTER_W-1:0]     letter;
        logic [wcm_pkg::WORD_INDEX_W-1:0] word_index;
        logic [wcm_pkg::WORD_VALUE_W-1:0] word_value;
    } text_beat_t;

    typedef struct packed {
        logic                      match;
        logic [wcm_pkg::POS_W-1:0] start_index;
    } match_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [wcm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wcm_pkg::CFG_W-1:0]     cfg_data;

    wcm_in_if  in_ch();
    wcm_out_if out_ch();

    word_concatenation_matcher #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predicted matcher state
    logic [wcm_pkg::LETTER_W-1:0]     hist [HIST_DEPTH];
    logic [wcm_pkg::WORD_VALUE_W-1:0] words [MAX_WORDS];
    logic [wcm_pkg::POS_W-1:0]        text_pos = '0;
    logic [wcm_pkg::CFG_W-1:0]        len_reg = 4'd1;
    logic [wcm_pkg::CFG_W-1:0]        cnt_reg = 4'd1;

    // bench bookkeeping
    text_beat_t    beat_q [$];
    match_result_t expected_q [$];
    int unsigned   issued = 0;
    int unsigned   resolved = 0;
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;
    int unsigned   send_gap = 0;
    int unsigned   recv_gap = 0;
    int unsigned   hold_left = 0;
    bit            hold_req = 1'b0;
    bit            calm = 1'b0;
    bit            in_took = 1'b0;
    logic [wcm_pkg::WORD_VALUE_W-1:0] phase_words [MAX_WORDS];

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // register value clamped to its usable range
    function automatic int unsigned clamp_reg(input logic [wcm_pkg::CFG_W-1:0] v,
                                              input int unsigned top);
        if (v == 0)
            return 1;
        if (32'(v) > top)
            return top;
        return 32'(v);
    endfunction

    // random bits for a full word field
    function automatic word_t junk_word();
        return word_t'({$urandom(), $urandom()});
    endfunction

    // bits of the first wl letters of a packed word
    function automatic logic [wcm_pkg::WORD_VALUE_W-1:0] word_mask(input int unsigned wl);
        return (40'd1 << (5 * wl)) - 40'd1;
    endfunction

    // window of the newest wl*wc letters against table slots 0..wc-1
    function automatic bit window_is_concat(input int unsigned wl, input int unsigned wc);
        bit                               used [MAX_WORDS] = '{default: 1'b0};
        logic [wcm_pkg::WORD_VALUE_W-1:0] chunk;
        logic [wcm_pkg::WORD_VALUE_W-1:0] mask;
        int unsigned                      age;
        bit                               found;
        mask = word_mask(wl);
        for (int unsigned c = 0; c < wc; c++)
        begin
            chunk = '0;
            found = 1'b0;
            for (int unsigned k = 0; k < wl; k++)
            begin
                age = wl * wc - 1 - (c * wl + k);
                chunk[5*k +: 5] = hist[age];
            end
            for (int unsigned s = 0; s < wc && !found; s++)
            begin
                if (!used[s] && ((words[s] & mask) == chunk))
                begin
                    used[s] = 1'b1;
                    found = 1'b1;
                end
            end
            if (!found)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the predicted state by one beat and return its result
    function automatic match_result_t apply_beat(input text_beat_t b);
        match_result_t r;
        int unsigned   wl;
        int unsigned   wc;
        int unsigned   total;
        logic [wcm_pkg::POS_W-1:0] pos;
        r = '0;
        case (b.action)
            wcm_pkg::ACT_LOAD:
                words[b.word_index] = b.word_value;
            wcm_pkg::ACT_RESTART:
            begin
                text_pos = '0;
                foreach (hist[i])
                    hist[i] = '0;
            end
            wcm_pkg::ACT_LETTER:
            begin
                wl = clamp_reg(len_reg, MAX_WORD_LEN);
                wc = clamp_reg(cnt_reg, MAX_WORDS);
                total = wl * wc;
                pos = text_pos;
                for (int i = HIST_DEPTH - 1; i > 0; i--)
                    hist[i] = hist[i-1];
                hist[0] = b.letter;
                if (text_pos != wcm_pkg::POS_MAX)
                    text_pos = text_pos + 1;
                if (64'(pos) + 1 >= 64'(total) && window_is_concat(wl, wc))
                begin
                    r.match = 1'b1;
                    r.start_index = pos + 32'd1 - 32'(total);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input match_result_t want,
                                 input match_result_t got);
        if (mismatches < 10)
            $display("mismatch (%s): expected match=%0b start=%0d, got match=%0b start=%0d",
                     what, want.match, want.start_index, got.match, got.start_index);
        mismatches++;
    endtask

    // monitor: check result beats, predict accepted input beats
    always @(posedge clk)
    begin : watch_beats
        match_result_t got;
        match_result_t want;
        text_beat_t    taken;
        if (rst_n)
        begin
            in_took = in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                got.match = out_ch.match;
                got.start_index = out_ch.start_index;
                resolved++;
                if (expected_q.size() == 0)
                    note_mismatch("result beat with nothing expected", '0, got);
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                        note_mismatch("field", want, got);
                end
            end
            if (in_took)
            begin
                taken.action = in_ch.action;
                taken.letter = in_ch.letter;
                taken.word_index = in_ch.word_index;
                taken.word_value = in_ch.word_value;
                expected_q = {expected_q, apply_beat(taken)};
            end
        end
    end

    // driver: input beats from the pending queue, with random gaps
    always @(negedge clk)
    begin : drive_text
        text_beat_t nxt;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_took)
        begin
            if (send_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap--;
            end
            else if (beat_q.size() != 0)
            begin
                nxt = beat_q.pop_front();
                in_ch.action <= nxt.action;
                in_ch.letter <= nxt.letter;
                in_ch.word_index <= nxt.word_index;
                in_ch.word_value <= nxt.word_value;
                in_ch.valid <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 6);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        else if (hold_left != 0)
            hold_left--;
    end

    // receiver ready with random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
            out_ch.ready <= 1'b0;
        else if (recv_gap != 0)
        begin
            out_ch.ready <= 1'b0;
            recv_gap--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 6);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_word_concatenation_matcher: FAIL");
            $finish;
        end
    end

    task automatic push_beat(input logic [wcm_pkg::ACTION_W-1:0] act, input letter_t l,
                             input slot_t idx, input word_t val);
        text_beat_t b;
        b.action = act;
        b.letter = l;
        b.word_index = idx;
        b.word_value = val;
        beat_q = {beat_q, b};
        issued++;
    endtask

    // letter beat, unused fields random
    task automatic push_letter(input letter_t l);
        push_beat(wcm_pkg::ACT_LETTER, l, slot_t'($urandom_range(0, 7)), junk_word());
    endtask

    // wait until every sent beat has its result back
    task automatic drain();
        while (resolved < issued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input wcm_pkg::cfg_reg_t idx,
                             input logic [wcm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == wcm_pkg::REG_WORD_LENGTH)
            len_reg = val;
        else
            cnt_reg = val;
    endtask

    // random word over a small alphabet, junk above the used letters
    function automatic word_t rand_word(input int unsigned wl, input int unsigned alpha);
        word_t w;
        w = junk_word();
        for (int unsigned k = 0; k < wl; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                w[5*k +: 5] = letter_t'($urandom_range(0, 31));
            else
                w[5*k +: 5] = letter_t'($urandom_range(0, alpha - 1));
        end
        return w;
    endfunction

    // one register setting: fresh table, then mostly well-formed windows
    task automatic run_phase(input logic [wcm_pkg::CFG_W-1:0] len_raw,
                             input logic [wcm_pkg::CFG_W-1:0] cnt_raw,
                             input int unsigned n_items, input bit with_hold,
                             input bit with_pause);
        int unsigned wl;
        int unsigned wc;
        int unsigned sent;
        int unsigned alpha;
        int unsigned pick;
        int unsigned n;
        int unsigned tmp;
        int unsigned order [MAX_WORDS];
        int          broken;
        int          j;
        bit          paused;
        word_t       w;
        letter_t     l;
        drain();
        write_reg(wcm_pkg::REG_WORD_LENGTH, len_raw);
        write_reg(wcm_pkg::REG_WORD_COUNT, cnt_raw);
        wl = clamp_reg(len_raw, MAX_WORD_LEN);
        wc = clamp_reg(cnt_raw, MAX_WORDS);
        alpha = $urandom_range(2, 4);
        sent = 0;
        paused = 1'b0;

        // table load, some slots duplicated with different junk
        for (int s = 0; s < MAX_WORDS; s++)
        begin
            if (s > 0 && $urandom_range(0, 3) == 0)
            begin
                w = junk_word();
                w = (phase_words[$urandom_range(0, s - 1)] & word_mask(wl)) | (w & ~word_mask(wl));
            end
            else
                w = rand_word(wl, alpha);
            phase_words[s] = w;
            push_beat(wcm_pkg::ACT_LOAD, letter_t'($urandom_range(0, 31)), slot_t'(s), w);
            sent++;
        end
        if (with_hold)
            hold_req = 1'b1;
        if ($urandom_range(0, 1) == 0)
        begin
            push_beat(wcm_pkg::ACT_RESTART, letter_t'($urandom_range(0, 31)),
                      slot_t'($urandom_range(0, 7)), junk_word());
            sent++;
        end

        while (sent < n_items)
        begin
            if (with_pause && !paused && sent >= n_items / 2)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // shuffled concatenation of the set, sometimes with one letter broken
                for (int i = 0; i < wc; i++)
                    order[i] = i;
                for (int i = wc - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                broken = ($urandom_range(0, 9) == 0) ? $urandom_range(0, wl * wc - 1) : -1;
                for (int unsigned c = 0; c < wc; c++)
                begin
                    for (int unsigned k = 0; k < wl; k++)
                    begin
                        l = phase_words[order[c]][5*k +: 5];
                        if (int'(c * wl + k) == broken)
                            l = l ^ (5'd1 << $urandom_range(0, 4));
                        push_letter(l);
                        sent++;
                    end
                end
            end
            else if (pick < 85)
            begin
                // noise letters, shifts the alignment
                n = $urandom_range(1, wl);
                for (int unsigned i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_letter(letter_t'($urandom_range(0, 31)));
                    else
                        push_letter(letter_t'($urandom_range(0, alpha - 1)));
                end
                sent += n;
            end
            else if (pick < 90)
            begin
                push_beat(wcm_pkg::ACT_RESTART, letter_t'($urandom_range(0, 31)),
                          slot_t'($urandom_range(0, 7)), junk_word());
                sent++;
            end
            else if (pick < 95)
            begin
                // reload a slot in the middle of the text
                j = $urandom_range(0, MAX_WORDS - 1);
                phase_words[j] = rand_word(wl, alpha);
                push_beat(wcm_pkg::ACT_LOAD, letter_t'($urandom_range(0, 31)), slot_t'(j),
                          phase_words[j]);
                sent++;
            end
            else
                push_beat(ACT_NOP, letter_t'($urandom_range(0, 31)),
                          slot_t'($urandom_range(0, 7)), junk_word());
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [wcm_pkg::CFG_W-1:0] len_plan [PHASES] = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd1, 4'd8,
                                                         4'd3, 4'd2, 4'd5, 4'd4, 4'd2};
        logic [wcm_pkg::CFG_W-1:0] cnt_plan [PHASES] = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd8, 4'd1,
                                                         4'd2, 4'd5, 4'd3, 4'd4, 4'd3};
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = wcm_pkg::REG_WORD_LENGTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = wcm_pkg::ACT_LOAD;
        in_ch.letter = '0;
        in_ch.word_index = '0;
        in_ch.word_value = '0;
        out_ch.ready = 1'b0;
        foreach (hist[i])
            hist[i] = '0;
        foreach (words[i])
            words[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single-letter words at reset settings, junk above the letter
        push_beat(wcm_pkg::ACT_LOAD, 5'd0, 3'd0, 40'hFF_FFFF_FFE0);
        for (int s = 1; s < MAX_WORDS - 1; s++)
            push_beat(wcm_pkg::ACT_LOAD, 5'd0, slot_t'(s), junk_word());
        push_beat(wcm_pkg::ACT_LOAD, 5'd0, 3'd7, 40'h0);
        push_beat(ACT_NOP, 5'h1F, 3'h7, '1);
        push_letter(5'd0);
        push_letter(5'd25);
        push_letter(5'd31);
        push_letter(5'd0);
        push_beat(wcm_pkg::ACT_RESTART, 5'd0, 3'd0, '0);
        push_letter(5'd0);

        // directed: two-letter duplicate pair, too few letters then matches
        drain();
        write_reg(wcm_pkg::REG_WORD_LENGTH, 4'd2);
        write_reg(wcm_pkg::REG_WORD_COUNT, 4'd2);
        push_beat(wcm_pkg::ACT_LOAD, 5'd0, 3'd0, 40'd32);
        push_beat(wcm_pkg::ACT_LOAD, 5'd0, 3'd1, {30'h3FFF_FFFF, 10'd32});
        for (int i = 0; i < 6; i++)
            push_letter(letter_t'(i % 2));

        // random phases, long hold in one, sender pauses in several, last one without idling
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                calm = 1'b1;
            run_phase(len_plan[p], cnt_plan[p], 150, p == 6, p % 3 == 1);
        end

        drain();
        repeat (150) @(negedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_word_concatenation_matcher: PASS");
        else
            $display("tb_word_concatenation_matcher: FAIL");
        $finish;
    end

endmodule
